FILE: rtl/tcpu_pkg.sv
// Shared types and constants for the toy CPU execute unit.
`default_nettype none
package tcpu_pkg;

  localparam int NUM_REGS  = 8;
  localparam int RF_AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int ADDR_BITS = 16;
  localparam int DW        = 16;
  localparam int OP_W      = 5;
  localparam int REG_W     = 3;

  localparam logic [DW-1:0] PC_RESET  = 16'h0000;
  localparam logic [DW-1:0] STACK_TOP = 16'h7FFF;
  localparam logic [DW-1:0] IO_BASE   = 16'hC000;

  typedef enum logic [OP_W-1:0] {
    OP_MOV  = 5'd0,
    OP_MOVI = 5'd1,
    OP_LD   = 5'd2,
    OP_ST   = 5'd3,
    OP_ADD  = 5'd4,
    OP_SUB  = 5'd5,
    OP_CMP  = 5'd6,
    OP_AND  = 5'd7,
    OP_OR   = 5'd8,
    OP_XOR  = 5'd9,
    OP_SHL  = 5'd10,
    OP_SHR  = 5'd11,
    OP_JMP  = 5'd12,
    OP_JZ   = 5'd13,
    OP_JNZ  = 5'd14,
    OP_CALL = 5'd15,
    OP_RET  = 5'd16,
    OP_PUSH = 5'd17,
    OP_POP  = 5'd18,
    OP_IN   = 5'd19,
    OP_OUT  = 5'd20,
    OP_HALT = 5'd21
  } op_t;

  typedef enum logic [1:0] {
    FLT_NONE    = 2'd0,
    FLT_OVF     = 2'd1,
    FLT_UNF     = 2'd2,
    FLT_UNKNOWN = 2'd3
  } fault_t;

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] addr;
    logic [DW-1:0]    data;
  } rf_wr_t;

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [ADDR_BITS-1:0] addr;
    logic [DW-1:0]        wdata;
  } dmem_req_t;

endpackage
`default_nettype wire

FILE: rtl/tcpu_regfile.sv
// Register file: two registered read ports, one write port.
`default_nettype none
module tcpu_regfile (
  input  wire logic                      clk,
  input  wire logic                      rd_en,
  input  wire logic [tcpu_pkg::RF_AW-1:0] rd_addr_a,
  input  wire logic [tcpu_pkg::RF_AW-1:0] rd_addr_b,
  input  wire tcpu_pkg::rf_wr_t          wr,
  output logic      [tcpu_pkg::DW-1:0]    rdata_a,
  output logic      [tcpu_pkg::DW-1:0]    rdata_b
);

  logic [tcpu_pkg::DW-1:0] mem [tcpu_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rdata_a <= mem[rd_addr_a];
      rdata_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tcpu_dmem.sv
// Data memory: single port, registered read data.
`default_nettype none
module tcpu_dmem (
  input  wire logic                   clk,
  input  wire tcpu_pkg::dmem_req_t    req,
  output logic      [tcpu_pkg::DW-1:0] rdata
);

  logic [tcpu_pkg::DW-1:0] mem [2**tcpu_pkg::ADDR_BITS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/toy_cpu_execute_unit.sv
// Top level of the toy CPU execute unit: execute and result stages.
//
// One decoded instruction enters per in_ transaction (action in in_tuser,
// register numbers and immediate in in_tdata); one result leaves per
// out_ transaction (pc, zero flag, halt state, fault, written value).
// Register file and data memory are synchronous RAMs with registered read data.
// An instruction reads its operands in the accept cycle and executes in the
// execute stage, then moves to the result register; ld, pop, in and ret
// also wait there for the data memory read before the result is offered.
// Throughput is one instruction per cycle while out_tready is high, but
// after a memory read the next instruction waits for the read data to commit.
// After reset the block sweeps the data memory and register file to zero,
// one word per cycle over all 65536 memory words, with in_tready low.
// A stalled out_tready holds the result register; one more instruction
// is taken into the execute stage and then in_tready drops.
// After a halt or fault, instructions change no state and report stopped.
`default_nettype none
module toy_cpu_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // reg_a[2:0], reg_b[5:3], immediate[21:6]
  input  wire logic [4:0]  in_tuser,   // action[4:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // next_pc[15:0], zero_out[16], stopped[17],
                                       // fault[19:18], written_value[35:20]
);

  localparam int DW = tcpu_pkg::DW;
  localparam int AW = tcpu_pkg::RF_AW;

  // clearing sweep
  logic                           clr_r;
  logic [tcpu_pkg::ADDR_BITS-1:0] clr_cnt_r;

  // architectural state
  logic [DW-1:0] pc_r, sp_r;
  logic          zero_r, halt_r;

  // execute stage
  logic                          ex_vld_r;
  logic [tcpu_pkg::OP_W-1:0]     ex_op_r;
  logic [tcpu_pkg::REG_W-1:0]    ex_ra_r, ex_rb_r;
  logic [DW-1:0]                 ex_imm_r;
  logic                          a_hit_r, b_hit_r;
  logic [DW-1:0]                 a_fwd_r, b_fwd_r;

  // result stage
  logic                          mem_vld_r, mem_pend_r, mem_to_pc_r, mem_ra_ok_r;
  logic [tcpu_pkg::REG_W-1:0]    mem_ra_r;
  logic [DW-1:0]                 mem_pc_r, mem_wv_r;
  logic                          mem_zero_r, mem_halt_r;
  logic [1:0]                    mem_fault_r;

  logic [DW-1:0] rf_rdata_a, rf_rdata_b, dm_rdata;
  tcpu_pkg::rf_wr_t    rf_wr;
  tcpu_pkg::dmem_req_t dm_req, ex_req;

  logic ex_go, in_fire, out_fire;
  logic ra_ok, rb_ok;
  logic [DW-1:0] a_val, b_val, pc_inc;
  logic [DW-1:0] pc_nxt, sp_nxt, res_nxt, wv_nxt;
  logic          zero_nxt, halt_nxt, reg_wr_nxt, rd_nxt, to_pc_nxt;
  tcpu_pkg::fault_t fault_nxt;

  logic [tcpu_pkg::REG_W-1:0] in_ra, in_rb;
  logic [DW-1:0]              in_imm;

  assign in_ra  = in_tdata[2:0];
  assign in_rb  = in_tdata[5:3];
  assign in_imm = in_tdata[21:6];

  assign out_tvalid = mem_vld_r & ~mem_pend_r;
  assign out_fire   = out_tvalid & out_tready;
  assign ex_go      = ex_vld_r & ~mem_pend_r & (~mem_vld_r | out_fire);
  assign in_tready  = ~clr_r & (~ex_vld_r | ex_go);
  assign in_fire    = in_tvalid & in_tready;

  assign out_tdata = {4'd0, mem_wv_r, mem_fault_r, mem_halt_r, mem_zero_r, mem_pc_r};

  // operand selection with forwarding
  assign ra_ok  = int'(ex_ra_r) < tcpu_pkg::NUM_REGS;
  assign rb_ok  = int'(ex_rb_r) < tcpu_pkg::NUM_REGS;
  assign a_val  = ra_ok ? (a_hit_r ? a_fwd_r : rf_rdata_a) : '0;
  assign b_val  = rb_ok ? (b_hit_r ? b_fwd_r : rf_rdata_b) : '0;
  assign pc_inc = pc_r + DW'(1);

  always_comb begin
    pc_nxt     = pc_inc;
    sp_nxt     = sp_r;
    zero_nxt   = zero_r;
    halt_nxt   = halt_r;
    fault_nxt  = tcpu_pkg::FLT_NONE;
    res_nxt    = '0;
    wv_nxt     = '0;
    reg_wr_nxt = 1'b0;
    rd_nxt     = 1'b0;
    to_pc_nxt  = 1'b0;
    ex_req     = '0;
    if (halt_r) begin
      pc_nxt = pc_r;
    end else begin
      unique case (ex_op_r)
        tcpu_pkg::OP_MOV:  begin res_nxt = b_val;      reg_wr_nxt = 1'b1; end
        tcpu_pkg::OP_MOVI: begin res_nxt = ex_imm_r;   reg_wr_nxt = 1'b1; end
        tcpu_pkg::OP_LD: begin
          ex_req.re   = 1'b1;
          ex_req.addr = b_val;
          rd_nxt      = 1'b1;
        end
        tcpu_pkg::OP_ST: begin
          ex_req.we    = 1'b1;
          ex_req.addr  = a_val;
          ex_req.wdata = b_val;
          wv_nxt       = b_val;
        end
        tcpu_pkg::OP_ADD:  begin res_nxt = a_val + b_val; reg_wr_nxt = 1'b1; end
        tcpu_pkg::OP_SUB:  begin res_nxt = a_val - b_val; reg_wr_nxt = 1'b1; end
        tcpu_pkg::OP_CMP:  zero_nxt = (a_val == b_val);
        tcpu_pkg::OP_AND:  begin res_nxt = a_val & b_val; reg_wr_nxt = 1'b1; end
        tcpu_pkg::OP_OR:   begin res_nxt = a_val | b_val; reg_wr_nxt = 1'b1; end
        tcpu_pkg::OP_XOR:  begin res_nxt = a_val ^ b_val; reg_wr_nxt = 1'b1; end
        tcpu_pkg::OP_SHL:  begin res_nxt = {a_val[DW-2:0], 1'b0}; reg_wr_nxt = 1'b1; end
        tcpu_pkg::OP_SHR:  begin res_nxt = {1'b0, a_val[DW-1:1]}; reg_wr_nxt = 1'b1; end
        tcpu_pkg::OP_JMP:  pc_nxt = ex_imm_r;
        tcpu_pkg::OP_JZ:   if (zero_r) pc_nxt = ex_imm_r;
        tcpu_pkg::OP_JNZ:  if (!zero_r) pc_nxt = ex_imm_r;
        tcpu_pkg::OP_CALL, tcpu_pkg::OP_PUSH: begin
          if (sp_r == '0) begin
            fault_nxt = tcpu_pkg::FLT_OVF;
          end else begin
            ex_req.we    = 1'b1;
            ex_req.addr  = sp_r;
            ex_req.wdata = (ex_op_r == tcpu_pkg::OP_CALL) ? pc_inc : a_val;
            wv_nxt       = ex_req.wdata;
            sp_nxt       = sp_r - DW'(1);
            if (ex_op_r == tcpu_pkg::OP_CALL) pc_nxt = ex_imm_r;
          end
        end
        tcpu_pkg::OP_RET, tcpu_pkg::OP_POP: begin
          if (sp_r == '1) begin
            fault_nxt = tcpu_pkg::FLT_UNF;
          end else begin
            sp_nxt      = sp_r + DW'(1);
            ex_req.re   = 1'b1;
            ex_req.addr = sp_nxt;
            rd_nxt      = 1'b1;
            to_pc_nxt   = (ex_op_r == tcpu_pkg::OP_RET);
          end
        end
        tcpu_pkg::OP_IN: begin
          ex_req.re   = 1'b1;
          ex_req.addr = tcpu_pkg::IO_BASE + ex_imm_r;
          rd_nxt      = 1'b1;
        end
        tcpu_pkg::OP_OUT: begin
          ex_req.we    = 1'b1;
          ex_req.addr  = tcpu_pkg::IO_BASE + ex_imm_r;
          ex_req.wdata = a_val;
          wv_nxt       = a_val;
        end
        tcpu_pkg::OP_HALT: halt_nxt = 1'b1;
        default:           fault_nxt = tcpu_pkg::FLT_UNKNOWN;
      endcase
      if (reg_wr_nxt) begin
        zero_nxt = (res_nxt == '0);
        wv_nxt   = res_nxt;
      end
      if (fault_nxt != tcpu_pkg::FLT_NONE) begin
        halt_nxt = 1'b1;
      end
    end
  end

  // register file write: sweep, memory-read commit, or execute
  always_comb begin
    rf_wr = '0;
    if (clr_r) begin
      rf_wr.en   = 1'b1;
      rf_wr.addr = AW'(clr_cnt_r);
    end else if (mem_pend_r && !mem_to_pc_r) begin
      rf_wr.en   = mem_ra_ok_r;
      rf_wr.addr = AW'(mem_ra_r);
      rf_wr.data = dm_rdata;
    end else if (ex_go && reg_wr_nxt) begin
      rf_wr.en   = ra_ok;
      rf_wr.addr = AW'(ex_ra_r);
      rf_wr.data = res_nxt;
    end
  end

  always_comb begin
    dm_req = '0;
    if (clr_r) begin
      dm_req.we   = 1'b1;
      dm_req.addr = clr_cnt_r;
    end else if (ex_go) begin
      dm_req = ex_req;
    end
  end

  tcpu_regfile u_regfile (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr_a (AW'(in_ra)),
    .rd_addr_b (AW'(in_rb)),
    .wr        (rf_wr),
    .rdata_a   (rf_rdata_a),
    .rdata_b   (rf_rdata_b)
  );

  tcpu_dmem u_dmem (
    .clk   (clk),
    .req   (dm_req),
    .rdata (dm_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_cnt_r  <= '0;
      pc_r       <= tcpu_pkg::PC_RESET;
      sp_r       <= tcpu_pkg::STACK_TOP;
      zero_r     <= 1'b0;
      halt_r     <= 1'b0;
      ex_vld_r   <= 1'b0;
      mem_vld_r  <= 1'b0;
      mem_pend_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + tcpu_pkg::ADDR_BITS'(1);
        if (clr_cnt_r == '1) clr_r <= 1'b0;
      end
      if (in_fire) begin
        ex_vld_r <= 1'b1;
      end else if (ex_go) begin
        ex_vld_r <= 1'b0;
      end
      if (ex_go) begin
        pc_r       <= pc_nxt;
        sp_r       <= sp_nxt;
        zero_r     <= zero_nxt;
        halt_r     <= halt_nxt;
        mem_vld_r  <= 1'b1;
        mem_pend_r <= rd_nxt;
      end else if (mem_pend_r) begin
        mem_pend_r <= 1'b0;
        if (mem_to_pc_r) begin
          pc_r <= dm_rdata;
        end else begin
          zero_r <= (dm_rdata == '0);
        end
      end else if (out_fire) begin
        mem_vld_r <= 1'b0;
      end
    end
  end

  // payload: execute-stage operands and forwarding
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_op_r  <= in_tuser;
      ex_ra_r  <= in_ra;
      ex_rb_r  <= in_rb;
      ex_imm_r <= in_imm;
      a_hit_r  <= rf_wr.en && (rf_wr.addr == AW'(in_ra));
      b_hit_r  <= rf_wr.en && (rf_wr.addr == AW'(in_rb));
      a_fwd_r  <= rf_wr.data;
      b_fwd_r  <= rf_wr.data;
    end else begin
      if (rf_wr.en && (rf_wr.addr == AW'(ex_ra_r))) begin
        a_hit_r <= 1'b1;
        a_fwd_r <= rf_wr.data;
      end
      if (rf_wr.en && (rf_wr.addr == AW'(ex_rb_r))) begin
        b_hit_r <= 1'b1;
        b_fwd_r <= rf_wr.data;
      end
    end
  end

  // payload: result stage
  always_ff @(posedge clk) begin
    if (ex_go) begin
      mem_pc_r    <= pc_nxt;
      mem_zero_r  <= zero_nxt;
      mem_halt_r  <= halt_nxt;
      mem_fault_r <= fault_nxt;
      mem_wv_r    <= wv_nxt;
      mem_to_pc_r <= to_pc_nxt;
      mem_ra_r    <= ex_ra_r;
      mem_ra_ok_r <= ra_ok;
    end else if (mem_pend_r) begin
      if (mem_to_pc_r) begin
        mem_pc_r <= dm_rdata;
      end else begin
        mem_zero_r <= (dm_rdata == '0);
        mem_wv_r   <= dm_rdata;
      end
    end
  end

endmodule
`default_nettype wire
